@@ sv/mouse_packet_cursor_tracker_assert.svh @@
// Assertion macros shared by the checker of the mouse cursor tracker.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH
`define MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent.
`define MPCT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define MPCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/mpct_pkg.sv @@
// Shared types and constants of the mouse cursor tracker.
// No dependencies; used by every RTL file of the block.
package mpct_pkg;

	// field widths
	localparam int BYTE_W      = 8;
	localparam int SIZE_W      = 13;
	localparam int CURSOR_W    = 12;
	localparam int CFG_IDX_W   = 1;
	localparam int COORD_BITS_DEF = 12;

	// controller status and header bits
	localparam logic [BYTE_W-1:0] ST_READY = 8'h01;
	localparam logic [BYTE_W-1:0] ST_MOUSE = 8'h20;
	localparam logic [BYTE_W-1:0] HDR_SYNC = 8'h08;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

	// reset values
	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd1024;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd768;
	localparam int POS_X_RESET = 512;
	localparam int POS_Y_RESET = 384;

	// completed packet handed from the framer to the cursor unit
	typedef struct packed {
		logic              complete;
		logic              left;
		logic [BYTE_W-1:0] dx;
		logic [BYTE_W-1:0] dy;
	} pkt_t;

endpackage

@@ sv/mpct_framer.sv @@
// Packet framer: filters usable polls and assembles three-byte mouse packets.
// Depends on mpct_pkg.
module mpct_framer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	input  logic                        advance,
	input  logic [mpct_pkg::BYTE_W-1:0] status,
	input  logic [mpct_pkg::BYTE_W-1:0] data,
	output mpct_pkg::pkt_t              pkt
);

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_XDELTA = 3'b010,
		PH_YDELTA = 3'b100
	} phase_t;

	phase_t                      phase_q;
	phase_t                      phase_d;
	logic [mpct_pkg::BYTE_W-1:0] header_q;
	logic [mpct_pkg::BYTE_W-1:0] xdelta_q;
	logic                        usable;
	logic                        is_sync;
	logic                        take_header;
	logic                        take_xdelta;
	logic                        complete;

	// use a byte only when data is ready and it came from the mouse
	assign usable = item_valid
		&& ((status & mpct_pkg::ST_READY) != '0)
		&& ((status & mpct_pkg::ST_MOUSE) != '0);
	assign is_sync = (data & mpct_pkg::HDR_SYNC) != '0;

	// next phase; drop unsynchronised header bytes
	always_comb begin
		phase_d     = phase_q;
		take_header = 1'b0;
		take_xdelta = 1'b0;
		complete    = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				if (usable && is_sync) begin
					phase_d     = PH_XDELTA;
					take_header = 1'b1;
				end
			end
			PH_XDELTA: begin
				if (usable) begin
					phase_d     = PH_YDELTA;
					take_xdelta = 1'b1;
				end
			end
			PH_YDELTA: begin
				if (usable) begin
					phase_d  = PH_HEADER;
					complete = 1'b1;
				end
			end
			default: begin
				phase_d = PH_HEADER;
			end
		endcase
	end

	// advance the framing state when the held request moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
		end else if (advance) begin
			phase_q <= phase_d;
		end
	end

	// hold the header and X delta bytes
	always_ff @(posedge clk) begin
		if (advance && take_header) begin
			header_q <= data;
		end
		if (advance && take_xdelta) begin
			xdelta_q <= data;
		end
	end

	assign pkt.complete = complete;
	assign pkt.left     = header_q[0];
	assign pkt.dx       = xdelta_q;
	assign pkt.dy       = data;

endmodule

@@ sv/mpct_cursor.sv @@
// Cursor unit: applies packet deltas, clamps to the screen, tracks the left button.
// Depends on mpct_pkg.
module mpct_cursor #(
	parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  mpct_pkg::pkt_t                pkt,
	input  logic [mpct_pkg::SIZE_W-1:0]   screen_width,
	input  logic [mpct_pkg::SIZE_W-1:0]   screen_height,
	output logic [COORD_BITS-1:0]         next_x,
	output logic [COORD_BITS-1:0]         next_y,
	output logic                          next_down,
	output logic                          next_pressed
);

	localparam logic [31:0] SPAN      = 32'(1) << COORD_BITS;
	localparam logic [31:0] COORD_MAX = SPAN - 32'd1;
	localparam logic [COORD_BITS-1:0] RESET_X = (mpct_pkg::POS_X_RESET > COORD_MAX)
		? COORD_BITS'(COORD_MAX) : COORD_BITS'(mpct_pkg::POS_X_RESET);
	localparam logic [COORD_BITS-1:0] RESET_Y = (mpct_pkg::POS_Y_RESET > COORD_MAX)
		? COORD_BITS'(COORD_MAX) : COORD_BITS'(mpct_pkg::POS_Y_RESET);

	logic [COORD_BITS-1:0]        pos_x_q;
	logic [COORD_BITS-1:0]        pos_y_q;
	logic                         button_q;
	logic [COORD_BITS-1:0]        top_x;
	logic [COORD_BITS-1:0]        top_y;
	logic signed [COORD_BITS+1:0] sum_x;
	logic signed [COORD_BITS+1:0] sum_y;
	logic                         update;

	// largest coordinate for a screen size: zero acts as one, oversize saturates
	function automatic logic [COORD_BITS-1:0] size_top(input logic [mpct_pkg::SIZE_W-1:0] sz);
		logic [COORD_BITS-1:0] r;
		if (sz == '0) begin
			r = '0;
		end else if (32'(sz) > SPAN) begin
			r = COORD_BITS'(COORD_MAX);
		end else begin
			r = COORD_BITS'(sz - mpct_pkg::SIZE_W'(1));
		end
		return r;
	endfunction

	// clamp a signed coordinate to [0, top]
	function automatic logic [COORD_BITS-1:0] clamp(
		input logic signed [COORD_BITS+1:0] v,
		input logic [COORD_BITS-1:0]        top
	);
		logic [COORD_BITS-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({2'b00, top})) begin
			r = top;
		end else begin
			r = v[COORD_BITS-1:0];
		end
		return r;
	endfunction

	assign top_x = size_top(screen_width);
	assign top_y = size_top(screen_height);

	// add X delta, subtract Y delta, both sign-extended from eight bits
	assign sum_x = $signed({2'b00, pos_x_q})
		+ $signed({{(COORD_BITS-6){pkt.dx[7]}}, pkt.dx});
	assign sum_y = $signed({2'b00, pos_y_q})
		- $signed({{(COORD_BITS-6){pkt.dy[7]}}, pkt.dy});

	assign next_x       = clamp(sum_x, top_x);
	assign next_y       = clamp(sum_y, top_y);
	assign next_down    = pkt.left;
	assign next_pressed = pkt.left & ~button_q;

	assign update = advance && pkt.complete;

	// commit position and button state on a completed packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q  <= RESET_X;
			pos_y_q  <= RESET_Y;
			button_q <= 1'b0;
		end else if (update) begin
			pos_x_q  <= next_x;
			pos_y_q  <= next_y;
			button_q <= pkt.left;
		end
	end

endmodule

@@ sv/mouse_packet_cursor_tracker.sv @@
// Top level of the mouse cursor tracker: input register, config, result register.
// Depends on mpct_pkg, mpct_framer and mpct_cursor.
//
// Usage:
//   Each input request is one controller poll (controller_status, data_byte)
//   on in_valid/in_stall. Polls whose status lacks data-ready or mouse-source
//   are consumed with no effect. Every third usable byte (after a header byte
//   with bit 3 set) completes a packet and yields one result request on
//   out_valid/out_stall carrying cursor_x, cursor_y, left_down, left_pressed.
//   Polls are taken one per cycle while in_stall is low; the single add-and-clamp
//   stage lies between the input and result registers. When out_stall holds a
//   result, polls that cause no result still drain; a packet-completing poll
//   waits in the input register and raises in_stall. Reset: cursor at (512,
//   384) (saturated to the coordinate range), button up, framer waiting for a
//   header, screen 1024 x 768, no result pending. The user must write screen
//   size via cfg_we/cfg_index/cfg_data only while idle; the block does not
//   enforce this.
module mouse_packet_cursor_tracker #(
	parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mpct_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mpct_pkg::SIZE_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [mpct_pkg::BYTE_W-1:0]    controller_status,
	input  logic [mpct_pkg::BYTE_W-1:0]    data_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [mpct_pkg::CURSOR_W-1:0]  cursor_x,
	output logic [mpct_pkg::CURSOR_W-1:0]  cursor_y,
	output logic                           left_down,
	output logic                           left_pressed
);

	logic [mpct_pkg::SIZE_W-1:0]   width_q;
	logic [mpct_pkg::SIZE_W-1:0]   height_q;
	logic                          item_valid_s1;
	logic [mpct_pkg::BYTE_W-1:0]   status_s1;
	logic [mpct_pkg::BYTE_W-1:0]   data_s1;
	logic                          valid_s2;
	logic [mpct_pkg::CURSOR_W-1:0] x_s2;
	logic [mpct_pkg::CURSOR_W-1:0] y_s2;
	logic                          down_s2;
	logic                          pressed_s2;
	mpct_pkg::pkt_t                pkt;
	logic [COORD_BITS-1:0]         next_x;
	logic [COORD_BITS-1:0]         next_y;
	logic                          next_down;
	logic                          next_pressed;
	logic                          accept;
	logic                          advance;
	logic                          out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mpct_pkg::WIDTH_RESET;
			height_q <= mpct_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == mpct_pkg::CFG_SCREEN_WIDTH) begin
				width_q <= cfg_data;
			end else if (cfg_index == mpct_pkg::CFG_SCREEN_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	// move the held poll on unless it completes a packet into a blocked result slot
	assign out_free = !valid_s2 || !out_stall;
	assign advance  = item_valid_s1 && (!pkt.complete || out_free);
	assign in_stall = item_valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (accept) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= controller_status;
			data_s1   <= data_byte;
		end
	end

	mpct_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid_s1),
		.advance    (advance),
		.status     (status_s1),
		.data       (data_s1),
		.pkt        (pkt)
	);

	mpct_cursor #(
		.COORD_BITS (COORD_BITS)
	) u_cursor (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.pkt           (pkt),
		.screen_width  (width_q),
		.screen_height (height_q),
		.next_x        (next_x),
		.next_y        (next_y),
		.next_down     (next_down),
		.next_pressed  (next_pressed)
	);

	// result register: load on a completed packet, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && pkt.complete) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && pkt.complete) begin
			x_s2       <= mpct_pkg::CURSOR_W'(next_x);
			y_s2       <= mpct_pkg::CURSOR_W'(next_y);
			down_s2    <= next_down;
			pressed_s2 <= next_pressed;
		end
	end

	assign out_valid    = valid_s2;
	assign cursor_x     = x_s2;
	assign cursor_y     = y_s2;
	assign left_down    = down_s2;
	assign left_pressed = pressed_s2;

endmodule

@@ sv/mpct_checker.sv @@
// Port-level checker for the mouse cursor tracker, bound to the top level.
// Depends on mouse_packet_cursor_tracker_assert.svh and mpct_pkg.
`include "mouse_packet_cursor_tracker_assert.svh"

module mpct_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [mpct_pkg::CURSOR_W-1:0] cursor_x,
	input logic [mpct_pkg::CURSOR_W-1:0] cursor_y,
	input logic                          left_down,
	input logic                          left_pressed
);

	// hold a stalled result request
	`MPCT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(cursor_x) && $stable(cursor_y) && $stable(left_down) && $stable(left_pressed), "stalled result changed")

	// a press edge always reports the button as down
	`MPCT_ASSERT_NOW(a_press_down, out_valid && left_pressed, left_down, "press without button down")

	// a fresh result follows an accepted poll through the input and result registers
	`MPCT_ASSERT_NOW(a_result_source, $rose(out_valid), $past(in_valid && !in_stall, 2), "result with no matching poll")

	// an empty result slot never blocks the input
	`MPCT_ASSERT_NOW(a_no_idle_stall, !out_valid, !in_stall, "input stalled while result slot empty")

endmodule

bind mouse_packet_cursor_tracker mpct_checker u_mpct_checker (.*);
